/* rtl/core/psp_pkg.sv */
// shared types and codes for the point to segment projection block
// no dependencies
`timescale 1ns / 1ps

package psp_pkg;

    // kind of result returned with each projection
    typedef enum logic [1:0] {
        KIND_INTERIOR = 2'd0,
        KIND_DEGEN    = 2'd1,
        KIND_ENDPOINT = 2'd2
    } t_kind;

    localparam int KIND_W = 2;

endpackage

/* rtl/core/psp_div_cell.sv */
// one cell of the restoring divider chain: one quotient bit per cell for two lanes
// uses psp_pkg for the width of the result kind carried alongside
`timescale 1ns / 1ps

module psp_div_cell
    import psp_pkg::*;
#(
    parameter int QUO_W  = 32,
    parameter int DEN_W  = 67,
    parameter int REM_W  = 99,
    parameter int SIDE_W = 68,
    parameter int SHIFT  = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem_x,
    input  logic [REM_W-1:0]  i_rem_y,
    input  logic [QUO_W-1:0]  i_quo_x,
    input  logic [QUO_W-1:0]  i_quo_y,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem_x,
    output logic [REM_W-1:0]  o_rem_y,
    output logic [QUO_W-1:0]  o_quo_x,
    output logic [QUO_W-1:0]  o_quo_y,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic [REM_W-1:0] w_dsh;
    logic [REM_W:0]   w_try_x;
    logic [REM_W:0]   w_try_y;
    logic             r_valid;
    logic [REM_W-1:0] r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [QUO_W-1:0] r_quo_x, r_quo_y, n_quo_x, n_quo_y;
    logic [DEN_W-1:0] r_den;
    logic [SIDE_W-1:0] r_side;

    // trial subtract of the shifted divisor in both lanes
    always_comb begin
        w_dsh   = REM_W'(i_den) << SHIFT;
        w_try_x = {1'b0, i_rem_x} - {1'b0, w_dsh};
        w_try_y = {1'b0, i_rem_y} - {1'b0, w_dsh};
        n_rem_x = w_try_x[REM_W] ? i_rem_x : w_try_x[REM_W-1:0];
        n_rem_y = w_try_y[REM_W] ? i_rem_y : w_try_y[REM_W-1:0];
        n_quo_x = {i_quo_x[QUO_W-2:0], ~w_try_x[REM_W]};
        n_quo_y = {i_quo_y[QUO_W-2:0], ~w_try_y[REM_W]};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
            r_den   <= i_den;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;
    assign o_den   = r_den;
    assign o_side  = r_side[SIDE_W-1 -: KIND_W] == KIND_INTERIOR ? r_side : r_side;

endmodule

/* rtl/core/point_segment_projection.sv */
// top level: projection of a point onto a 2-d segment, exact integer arithmetic
// uses psp_pkg and a chain of psp_div_cell dividers
`timescale 1ns / 1ps

// Usage
// Input channel i_valid / o_ready carries a query point P and segment A..B.
// Output channel o_valid / i_ready returns proj_x, proj_y and proj_kind.
// Every input transaction gives exactly one output transaction, in order.
// The pipeline has five setup stages (differences, products, sums and range
// test, two for numerator times direction split into partial products), one
// cell per quotient bit in the divider chain, and the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// every stage holds one item, so COORD_BITS + 6 items are in flight at once.
// When the receiver stalls with a result waiting, the whole pipe holds and
// o_ready drops; no stage advances until that result is taken.
// Reset (synchronous, active low) clears all valid flags; nothing else is
// held between items.
// proj_kind: interior projection, degenerate segment (A returned) or the
// nearer endpoint (B on a tie).
module point_segment_projection
    import psp_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic signed [COORD_BITS-1:0] i_seg_a_x,
    input  logic signed [COORD_BITS-1:0] i_seg_a_y,
    input  logic signed [COORD_BITS-1:0] i_seg_b_x,
    input  logic signed [COORD_BITS-1:0] i_seg_b_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_proj_x,
    output logic signed [COORD_BITS-1:0] o_proj_y,
    output logic [1:0]                   o_proj_kind
);

    localparam int C      = COORD_BITS;
    localparam int W1     = C + 1;
    localparam int P_W    = 2 * C + 2;
    localparam int DEN_W  = 2 * C + 3;
    localparam int T_W    = 3 * C + 3;
    localparam int SIDE_W = 2 * C + 4;
    localparam int F_W    = C + 2;
    localparam int LO_W   = C + 1;
    localparam int HI_W   = DEN_W - LO_W;
    localparam int PL_W   = LO_W + C;
    localparam int PH_W   = HI_W + C;

    logic w_en;

    // pipe moves whenever the output register is free or being emptied
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage 1: differences
    logic                 r_v1;
    logic signed [C-1:0]  r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [W1-1:0] r1_dx, r1_dy, r1_ex, r1_ey, r1_fx, r1_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax <= i_seg_a_x;
            r1_ay <= i_seg_a_y;
            r1_bx <= i_seg_b_x;
            r1_by <= i_seg_b_y;
            r1_dx <= W1'(i_seg_b_x) - W1'(i_seg_a_x);
            r1_dy <= W1'(i_seg_b_y) - W1'(i_seg_a_y);
            r1_ex <= W1'(i_seg_b_x) - W1'(i_query_x);
            r1_ey <= W1'(i_seg_b_y) - W1'(i_query_y);
            r1_fx <= W1'(i_seg_a_x) - W1'(i_query_x);
            r1_fy <= W1'(i_seg_a_y) - W1'(i_query_y);
        end
    end

    // stage 2: products
    logic                  r_v2, r2_degen;
    logic signed [C-1:0]   r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [W1-1:0]  r2_dx, r2_dy;
    logic signed [P_W-1:0] r2_dd_x, r2_dd_y, r2_nm_x, r2_nm_y;
    logic signed [P_W-1:0] r2_da_x, r2_da_y, r2_db_x, r2_db_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_bx    <= r1_bx;
            r2_by    <= r1_by;
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_degen <= (r1_dx == '0) && (r1_dy == '0);
            r2_dd_x  <= P_W'(r1_dx) * P_W'(r1_dx);
            r2_dd_y  <= P_W'(r1_dy) * P_W'(r1_dy);
            r2_nm_x  <= P_W'(r1_ex) * P_W'(r1_dx);
            r2_nm_y  <= P_W'(r1_ey) * P_W'(r1_dy);
            r2_da_x  <= P_W'(r1_fx) * P_W'(r1_fx);
            r2_da_y  <= P_W'(r1_fy) * P_W'(r1_fy);
            r2_db_x  <= P_W'(r1_ex) * P_W'(r1_ex);
            r2_db_y  <= P_W'(r1_ey) * P_W'(r1_ey);
        end
    end

    // stage 3: sums, range test and endpoint choice
    logic signed [DEN_W-1:0] w_den, w_num, w_da, w_db;
    t_kind                   n3_kind;
    logic signed [C-1:0]     n3_rx, n3_ry;

    always_comb begin
        w_den = DEN_W'(r2_dd_x) + DEN_W'(r2_dd_y);
        w_num = DEN_W'(r2_nm_x) + DEN_W'(r2_nm_y);
        w_da  = DEN_W'(r2_da_x) + DEN_W'(r2_da_y);
        w_db  = DEN_W'(r2_db_x) + DEN_W'(r2_db_y);
        if (r2_degen) begin
            n3_kind = KIND_DEGEN;
            n3_rx   = r2_ax;
            n3_ry   = r2_ay;
        end else if (!w_num[DEN_W-1] && (w_num <= w_den)) begin
            n3_kind = KIND_INTERIOR;
            n3_rx   = r2_bx;
            n3_ry   = r2_by;
        end else begin
            n3_kind = KIND_ENDPOINT;
            n3_rx   = (w_da < w_db) ? r2_ax : r2_bx;
            n3_ry   = (w_da < w_db) ? r2_ay : r2_by;
        end
    end

    logic                 r_v3;
    t_kind                r3_kind;
    logic signed [C-1:0]  r3_rx, r3_ry;
    logic signed [W1-1:0] r3_dx, r3_dy;
    logic [DEN_W-1:0]     r3_den, r3_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind <= n3_kind;
            r3_rx   <= n3_rx;
            r3_ry   <= n3_ry;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_den  <= w_den;
            r3_num  <= w_num;
        end
    end

    // stage 4: partial products of numerator times direction magnitude, per lane
    logic [W1-1:0] w_adx, w_ady;

    assign w_adx = r3_dx[W1-1] ? W1'(-r3_dx) : r3_dx;
    assign w_ady = r3_dy[W1-1] ? W1'(-r3_dy) : r3_dy;

    logic              r_v4;
    logic [PL_W-1:0]   r4_lo_x, r4_lo_y;
    logic [PH_W-1:0]   r4_hi_x, r4_hi_y;
    logic [DEN_W-1:0]  r4_den;
    logic [SIDE_W-1:0] r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_lo_x <= PL_W'(r3_num[LO_W-1:0]) * PL_W'(w_adx[C-1:0]);
            r4_lo_y <= PL_W'(r3_num[LO_W-1:0]) * PL_W'(w_ady[C-1:0]);
            r4_hi_x <= PH_W'(r3_num[DEN_W-1:LO_W]) * PH_W'(w_adx[C-1:0]);
            r4_hi_y <= PH_W'(r3_num[DEN_W-1:LO_W]) * PH_W'(w_ady[C-1:0]);
            r4_den  <= r3_den;
            r4_side <= {r3_kind, r3_dx[W1-1], r3_dy[W1-1], r3_rx, r3_ry};
        end
    end

    // stage 5: combine partial products into the dividend
    logic              r_v5;
    logic [T_W-1:0]    r5_tx, r5_ty;
    logic [DEN_W-1:0]  r5_den;
    logic [SIDE_W-1:0] r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_tx   <= T_W'(r4_lo_x) + (T_W'(r4_hi_x) << LO_W);
            r5_ty   <= T_W'(r4_lo_y) + (T_W'(r4_hi_y) << LO_W);
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // divider chain: one cell per quotient bit, most significant first
    logic              c_valid [C+1];
    logic [T_W-1:0]    c_rem_x [C+1];
    logic [T_W-1:0]    c_rem_y [C+1];
    logic [C-1:0]      c_quo_x [C+1];
    logic [C-1:0]      c_quo_y [C+1];
    logic [DEN_W-1:0]  c_den   [C+1];
    logic [SIDE_W-1:0] c_side  [C+1];

    assign c_valid[0] = r_v5;
    assign c_rem_x[0] = r5_tx;
    assign c_rem_y[0] = r5_ty;
    assign c_quo_x[0] = '0;
    assign c_quo_y[0] = '0;
    assign c_den[0]   = r5_den;
    assign c_side[0]  = r5_side;

    for (genvar g = 0; g < C; g++) begin : g_cell
        psp_div_cell #(
            .QUO_W  (C),
            .DEN_W  (DEN_W),
            .REM_W  (T_W),
            .SIDE_W (SIDE_W),
            .SHIFT  (C - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_valid[g]),
            .i_rem_x (c_rem_x[g]),
            .i_rem_y (c_rem_y[g]),
            .i_quo_x (c_quo_x[g]),
            .i_quo_y (c_quo_y[g]),
            .i_den   (c_den[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem_x (c_rem_x[g+1]),
            .o_rem_y (c_rem_y[g+1]),
            .o_quo_x (c_quo_x[g+1]),
            .o_quo_y (c_quo_y[g+1]),
            .o_den   (c_den[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // final correction: B minus the truncated quotient, with truncation toward zero
    logic [SIDE_W-1:0]    w_side;
    t_kind                w_kind;
    logic                 w_sx, w_sy;
    logic signed [C-1:0]  w_rx, w_ry;
    logic signed [F_W-1:0] w_vx, w_vy, n_px, n_py;

    assign w_side = c_side[C];
    assign w_kind = t_kind'(w_side[SIDE_W-1 -: KIND_W]);
    assign w_sx   = w_side[2*C+1];
    assign w_sy   = w_side[2*C];
    assign w_rx   = w_side[2*C-1:C];
    assign w_ry   = w_side[C-1:0];

    always_comb begin
        w_vx = w_sx ? F_W'(w_rx) + $signed({2'b00, c_quo_x[C]})
                    : F_W'(w_rx) - $signed({2'b00, c_quo_x[C]});
        w_vy = w_sy ? F_W'(w_ry) + $signed({2'b00, c_quo_y[C]})
                    : F_W'(w_ry) - $signed({2'b00, c_quo_y[C]});
        n_px = w_vx;
        n_py = w_vy;
        if (c_rem_x[C] != '0) begin
            if (!w_sx && (w_vx > F_W'(0))) begin
                n_px = w_vx - F_W'(1);
            end else if (w_sx && w_vx[F_W-1]) begin
                n_px = w_vx + F_W'(1);
            end
        end
        if (c_rem_y[C] != '0) begin
            if (!w_sy && (w_vy > F_W'(0))) begin
                n_py = w_vy - F_W'(1);
            end else if (w_sy && w_vy[F_W-1]) begin
                n_py = w_vy + F_W'(1);
            end
        end
        if (w_kind != KIND_INTERIOR) begin
            n_px = F_W'(w_rx);
            n_py = F_W'(w_ry);
        end
    end

    // output register
    logic                r_out_valid;
    logic signed [C-1:0] r_px, r_py;
    t_kind               r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= c_valid[C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px   <= n_px[C-1:0];
            r_py   <= n_py[C-1:0];
            r_kind <= w_kind;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_proj_x    = r_px;
    assign o_proj_y    = r_py;
    assign o_proj_kind = r_kind;

    // checks
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_proj_kind == KIND_INTERIOR) || (o_proj_kind == KIND_DEGEN)
                    || (o_proj_kind == KIND_ENDPOINT))
        else $error("illegal projection kind");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v5) && $stable(r5_tx))
        else $error("pipeline moved during stall");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_en) |=> r_v4)
        else $error("item lost between stages");

    a_interior_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r3_kind == KIND_INTERIOR) |-> (r3_num <= r3_den))
        else $error("interior item outside segment range");

endmodule

/* verif/point_segment_projection_tb.sv */
// testbench for point_segment_projection: directed and random projections,
// checked against an exact integer predictor; depends on psp_pkg and the rtl
`timescale 1ns / 1ps

module point_segment_projection_tb
    import psp_pkg::*;
();

    localparam int CB = 32;
    localparam int LAT = CB + 6;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_LEN = 80;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord px;
        t_coord py;
        t_kind  kind;
    } t_proj;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_coord i_query_x = '0, i_query_y = '0;
    t_coord i_seg_a_x = '0, i_seg_a_y = '0, i_seg_b_x = '0, i_seg_b_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_coord o_proj_x, o_proj_y;
    logic [1:0] o_proj_kind;

    t_proj proj_queue[$];
    int n_mismatch = 0;
    int idle_cycles = 0;
    bit allow_idle = 1'b1;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_off = 0;
    int stall_left = 0;

    always #4 i_clk = ~i_clk;

    point_segment_projection #(.COORD_BITS(CB)) uut (.*);

    // exact projection, widths large enough that nothing overflows
    function automatic t_proj project(t_coord qx, t_coord qy, t_coord ax, t_coord ay,
                                      t_coord bx, t_coord by);
        logic signed [199:0] dx, dy, den, num, nx, ny, da, db;
        t_proj r;
        dx = 200'(signed'(bx)) - 200'(signed'(ax));
        dy = 200'(signed'(by)) - 200'(signed'(ay));
        if (dx == 0 && dy == 0) begin
            r.px = ax; r.py = ay; r.kind = KIND_DEGEN;
            return r;
        end
        den = dx * dx + dy * dy;
        num = (200'(signed'(bx)) - qx) * dx + (200'(signed'(by)) - qy) * dy;
        if (num >= 0 && num <= den) begin
            nx = 200'(signed'(bx)) * den - num * dx;
            ny = 200'(signed'(by)) * den - num * dy;
            r.px = t_coord'(nx / den);
            r.py = t_coord'(ny / den);
            r.kind = KIND_INTERIOR;
        end else begin
            da = (200'(signed'(ax)) - qx) * (200'(signed'(ax)) - qx)
               + (200'(signed'(ay)) - qy) * (200'(signed'(ay)) - qy);
            db = (200'(signed'(bx)) - qx) * (200'(signed'(bx)) - qx)
               + (200'(signed'(by)) - qy) * (200'(signed'(by)) - qy);
            if (da < db) begin
                r.px = ax; r.py = ay;
            end else begin
                r.px = bx; r.py = by;
            end
            r.kind = KIND_ENDPOINT;
        end
        return r;
    endfunction

    // send one transaction, with an optional idle burst ahead of it
    task automatic send_query(t_coord qx, t_coord qy, t_coord ax, t_coord ay,
                              t_coord bx, t_coord by);
        int gap;
        t_proj pred;
        if (allow_idle && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_query_x <= qx; i_query_y <= qy;
        i_seg_a_x <= ax; i_seg_a_y <= ay;
        i_seg_b_x <= bx; i_seg_b_y <= by;
        pred = project(qx, qy, ax, ay, bx, by);
        proj_queue = {proj_queue, pred};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(200)) - 100);
            default: return t_coord'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic test_directed();
        t_coord mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        send_query(5, 5, 3, -4, 3, -4);            // degenerate segment
        send_query(mx, mn, mn, mx, mn, mx);
        send_query(0, 5, 0, 0, 10, 0);             // interior
        send_query(10, 3, 0, 0, 10, 0);            // theta zero gives b
        send_query(0, 7, 0, 0, 10, 0);             // theta one gives a
        send_query(-5, 1, 0, 0, 10, 0);            // beyond a
        send_query(15, 1, 0, 0, 10, 0);            // beyond b
        send_query(3, -7, 0, 0, 1, 3);             // beyond a, a nearer
        send_query(-3, 7, 0, 0, -1, -3);
        send_query(mx, mx, mn, mn, mx, mx);
        send_query(mn, mn, mn, mn, mx, mx);
        send_query(mx, mn, mn, mn, mx, mx);
        send_query(mn, mx, mx, mn, mn, mx);
        send_query(mn, mn, mx, mx, mx, mn);
        send_query(mx, mx, 0, 0, -1, -1);
        send_query(-1, -1, mx, mn, mx, mn);
        send_query(0, 0, 1, 0, 0, 1);
        send_query(100, 100, 0, 0, 10, 0);        // far outside, b nearer
    endtask

    // equal distances from both ends when outside the segment are only
    // reachable with theta inside, so the endpoint tie is never hit; random covers the rest
    task automatic test_random(int count);
        int mode;
        t_coord ax, ay;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(2);
            ax = rand_coord(mode);
            ay = rand_coord(mode);
            if ($urandom_range(15) == 0)
                send_query(rand_coord(mode), rand_coord(mode), ax, ay, ax, ay);
            else
                send_query(rand_coord(mode), rand_coord(mode), ax, ay,
                           rand_coord(mode), rand_coord(mode));
        end
    endtask

    task automatic test_backpressure();
        hold_reqs++;
        test_random(60);
    endtask

    task automatic test_no_idle();
        allow_idle = 1'b0;
        test_random(150);
        i_valid <= 1'b0;
    endtask

    // receiver: random stall bursts, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_off <= 0;
            stall_left <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_off <= HOLD_LEN - 1;
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (allow_idle && $urandom_range(3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_proj want;
        if (i_rst_n && o_valid && i_ready) begin
            if (proj_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result x=%0d y=%0d kind=%0d",
                             o_proj_x, o_proj_y, o_proj_kind);
            end else begin
                want = proj_queue.pop_front();
                if (want.px !== o_proj_x || want.py !== o_proj_y
                        || want.kind !== o_proj_kind) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.px, want.py, want.kind,
                                 o_proj_x, o_proj_y, o_proj_kind);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(650);
        test_backpressure();
        test_no_idle();
        i_valid <= 1'b0;
        while (proj_queue.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        if (n_mismatch == 0 && proj_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* point_segment_projection.f */
rtl/core/psp_pkg.sv
rtl/core/psp_div_cell.sv
rtl/core/point_segment_projection.sv
verif/point_segment_projection_tb.sv
